### hw/rtl/bilinear_image_resize_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bilinear resize block
// Shared concurrent checks, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_IMAGE_RESIZE_TOP_DEFINES_SVH
`define BILINEAR_IMAGE_RESIZE_TOP_DEFINES_SVH

// Condition holds at every clock edge out of reset
`define BIR_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next
`define BIR_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### hw/rtl/bir_pkg.sv
// ---------------------------------------------------------------------------
// bir_pkg
// Constants, types and helper functions of the bilinear resize block.
// ---------------------------------------------------------------------------
package bir_pkg;

	localparam int MAX_SRC_WIDTH  = 512;
	localparam int MAX_SRC_HEIGHT = 512;
	localparam int MAX_DST_DIM    = 4096;

	localparam int SDIM_W    = 10;
	localparam int DDIM_W    = 13;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int COORD_W   = 12;
	localparam int PIX_W     = 8;

	localparam int SRC_WIDTH_RST  = 512;
	localparam int SRC_HEIGHT_RST = 512;
	localparam int DST_WIDTH_RST  = 512;
	localparam int DST_HEIGHT_RST = 512;

	localparam int MAX_SRC_DIM = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ?
		MAX_SRC_WIDTH : MAX_SRC_HEIGHT;
	localparam int CELL_W  = $clog2(MAX_SRC_DIM);
	localparam int FRAC_W  = 11;
	localparam int WT_W    = FRAC_W + 1;
	localparam int QB      = CELL_W + FRAC_W;
	localparam int PROD_W  = COORD_W + 1 + SDIM_W;
	localparam int DEN_W   = DDIM_W + 1;
	localparam int BANK_AW = 2 * (CELL_W - 1);
	localparam int BANK_DEPTH = 2 ** BANK_AW;
	localparam int SUM_W   = PIX_W + WT_W;
	localparam int MUL_W   = WT_W + SUM_W - 4;
	localparam int VSUM_W  = MUL_W - 16 + 1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [WT_W-1:0] COEF_ONE = WT_W'(2 ** FRAC_W);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH,
		REG_SRC_HEIGHT,
		REG_DST_WIDTH,
		REG_DST_HEIGHT
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_READ,
		KIND_ERROR
	} kind_t;

	typedef struct packed {
		logic [SDIM_W-1:0] sw;
		logic [SDIM_W-1:0] sh;
		logic [DDIM_W-1:0] dw;
		logic [DDIM_W-1:0] dh;
	} dims_t;

	typedef struct packed {
		kind_t             kind;
		logic [CELL_W-1:0] wx;
		logic [CELL_W-1:0] wy;
		logic [PIX_W-1:0]  wval;
		logic [PROD_W-1:0] prodx;
		logic [PROD_W-1:0] prody;
	} fe_t;

	typedef struct packed {
		kind_t             kind;
		logic              negx;
		logic              negy;
		logic [CELL_W-1:0] wx;
		logic [CELL_W-1:0] wy;
		logic [PIX_W-1:0]  wval;
	} bk_pay_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QB-1:0]    low;
		logic [QB-1:0]    quo;
	} div_t;

	typedef struct packed {
		logic [CELL_W-1:0] c0;
		logic [CELL_W-1:0] c1;
		logic [WT_W-1:0]   w1;
	} axis_t;

	// One restoring division step: shift in the next dividend bit
	function automatic div_t div_step(input div_t d, input logic [DEN_W-1:0] den);
		logic [DEN_W:0] rem2;
		logic           ge;
		div_t           n;
		rem2  = {d.rem, d.low[QB-1]};
		ge    = rem2 >= {1'b0, den};
		n.rem = ge ? DEN_W'(rem2 - {1'b0, den}) : rem2[DEN_W-1:0];
		n.low = {d.low[QB-2:0], 1'b0};
		n.quo = {d.quo[QB-2:0], ge};
		return n;
	endfunction

endpackage

### hw/rtl/bir_if.sv
// ---------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for incoming pixel requests and outgoing results.
// ---------------------------------------------------------------------------
interface bir_in_if import bir_pkg::*;;
	logic               valid;
	logic               ready;
	logic               func;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [PIX_W-1:0]   pixel_value;

	modport source(output valid, func, pixel_x, pixel_y, pixel_value, input ready);
	modport sink(input valid, func, pixel_x, pixel_y, pixel_value, output ready);
endinterface

interface bir_out_if import bir_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] result_pixel;
	logic             status;

	modport source(output valid, result_pixel, status, input ready);
	modport sink(input valid, result_pixel, status, output ready);
endinterface

### hw/rtl/bir_ram.sv
// ---------------------------------------------------------------------------
// bir_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bir_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

### hw/rtl/bir_fifo.sv
// ---------------------------------------------------------------------------
// bir_fifo
// Short queue between the request front end and the compute back end.
// ---------------------------------------------------------------------------
`include "bilinear_image_resize_top_defines.svh"

module bir_fifo import bir_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  fe_t  wdata,
	output logic full,
	input  logic pop,
	output logic valid,
	output fe_t  rdata
);
	fe_t                mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH);
	assign valid = cnt_q != '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	`BIR_ASSERT(a_fifo_cnt, cnt_q <= (FIFO_AW + 1)'(FIFO_DEPTH), "queue count overflow")
	`BIR_NEXT(a_fifo_fill, (push && !pop), (cnt_q != '0), "queue empty after push")
	`BIR_ASSERT(a_fifo_pop, !pop || valid, "pop from empty queue")
endmodule

### hw/rtl/bir_front.sv
// ---------------------------------------------------------------------------
// bir_front
// Register file, request classification and axis product for the queue.
// ---------------------------------------------------------------------------
module bir_front import bir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	bir_in_if.sink               req,
	input  logic                 full,
	output logic                 push,
	output fe_t                  entry,
	output dims_t                dims
);
	logic [SDIM_W-1:0] src_width_q;
	logic [SDIM_W-1:0] src_height_q;
	logic [DDIM_W-1:0] dst_width_q;
	logic [DDIM_W-1:0] dst_height_q;
	logic              err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SDIM_W'(SRC_WIDTH_RST);
			src_height_q <= SDIM_W'(SRC_HEIGHT_RST);
			dst_width_q  <= DDIM_W'(DST_WIDTH_RST);
			dst_height_q <= DDIM_W'(DST_HEIGHT_RST);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[SDIM_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[SDIM_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= cfg_data[DDIM_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= cfg_data[DDIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Saturate each dimension into its legal range
	always_comb begin
		dims.sw = (src_width_q == '0) ? SDIM_W'(1) :
			(src_width_q > SDIM_W'(MAX_SRC_WIDTH)) ? SDIM_W'(MAX_SRC_WIDTH) : src_width_q;
		dims.sh = (src_height_q == '0) ? SDIM_W'(1) :
			(src_height_q > SDIM_W'(MAX_SRC_HEIGHT)) ? SDIM_W'(MAX_SRC_HEIGHT) : src_height_q;
		dims.dw = (dst_width_q == '0) ? DDIM_W'(1) :
			(dst_width_q > DDIM_W'(MAX_DST_DIM)) ? DDIM_W'(MAX_DST_DIM) : dst_width_q;
		dims.dh = (dst_height_q == '0) ? DDIM_W'(1) :
			(dst_height_q > DDIM_W'(MAX_DST_DIM)) ? DDIM_W'(MAX_DST_DIM) : dst_height_q;
	end

	assign req.ready = !full;
	assign push      = req.valid && !full;

	always_comb begin
		if (req.func == FUNC_WRITE) begin
			err = (req.pixel_x >= COORD_W'(dims.sw)) || (req.pixel_y >= COORD_W'(dims.sh));
		end else begin
			err = (DDIM_W'(req.pixel_x) >= dims.dw) || (DDIM_W'(req.pixel_y) >= dims.dh);
		end
		entry.kind  = err ? KIND_ERROR : ((req.func == FUNC_WRITE) ? KIND_WRITE : KIND_READ);
		entry.wx    = req.pixel_x[CELL_W-1:0];
		entry.wy    = req.pixel_y[CELL_W-1:0];
		entry.wval  = req.pixel_value;
		// (2d + 1) * src, the scaled center of the destination pixel
		entry.prodx = {req.pixel_x, 1'b1} * dims.sw;
		entry.prody = {req.pixel_y, 1'b1} * dims.sh;
	end
endmodule

### hw/rtl/bir_back.sv
// ---------------------------------------------------------------------------
// bir_back
// Division pipeline, banked source image and two-pass bilinear blend.
// ---------------------------------------------------------------------------
`include "bilinear_image_resize_top_defines.svh"

module bir_back import bir_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  dims_t dims,
	input  logic  fq_valid,
	input  fe_t   fq_data,
	output logic  fq_pop,
	bir_out_if.source rsp
);
	logic              adv;
	logic [DEN_W-1:0]  denx;
	logic [DEN_W-1:0]  deny;
	logic [PROD_W-1:0] tx;
	logic [PROD_W-1:0] ty;
	bk_pay_t           pay0;
	div_t              dx0;
	div_t              dy0;

	logic    vld_q [QB+1];
	bk_pay_t pay_q [QB+1];
	div_t    dx_q  [QB+1];
	div_t    dy_q  [QB+1];

	logic    vld_s1;
	bk_pay_t pay_s1;
	axis_t   ax_s1;
	axis_t   ay_s1;

	logic    vld_s2;
	kind_t   kind_s2;
	axis_t   ax_s2;
	axis_t   ay_s2;

	logic [PIX_W-1:0]   rd [4];
	logic [PIX_W-1:0]   p00, p10, p01, p11;
	logic [WT_W-1:0]    a0;

	logic               vld_s3;
	kind_t              kind_s3;
	logic [WT_W-1:0]    b1_s3;
	logic [SUM_W-1:0]   s0_s3;
	logic [SUM_W-1:0]   s1_s3;

	logic               vld_s4;
	kind_t              kind_s4;
	logic [MUL_W-1:0]   m0_s4;
	logic [MUL_W-1:0]   m1_s4;
	logic [VSUM_W-1:0]  vsum;

	logic               out_vld_q;
	logic [PIX_W-1:0]   result_q;
	logic               status_q;

	function automatic axis_t axis_fin(input div_t d, input logic neg,
		input logic [DEN_W-1:0] den, input logic [SDIM_W-1:0] sdim);
		logic [CELL_W-1:0] c;
		logic [FRAC_W-1:0] f;
		logic              up;
		logic [SDIM_W-1:0] last;
		axis_t             a;
		c    = d.quo[QB-1:FRAC_W];
		f    = d.quo[FRAC_W-1:0];
		// round to nearest, ties to even
		up   = ({d.rem, 1'b0} > {1'b0, den}) || (({d.rem, 1'b0} == {1'b0, den}) && f[0]);
		last = sdim - 1'b1;
		if (neg) begin
			a.c0 = '0;
			a.w1 = '0;
		end else if (SDIM_W'(c) >= last) begin
			a.c0 = CELL_W'(last);
			a.w1 = '0;
		end else begin
			a.c0 = c;
			a.w1 = WT_W'(f) + WT_W'(up);
		end
		a.c1 = ((SDIM_W'(a.c0) + 1'b1) < sdim) ? a.c0 + 1'b1 : a.c0;
		return a;
	endfunction

	assign adv    = !out_vld_q || rsp.ready;
	assign fq_pop = adv && fq_valid;
	assign denx   = {dims.dw, 1'b0};
	assign deny   = {dims.dh, 1'b0};

	// Subtract the destination size and seed the dividers with t * 2^FRAC_W
	always_comb begin
		tx        = fq_data.prodx - PROD_W'(dims.dw);
		ty        = fq_data.prody - PROD_W'(dims.dh);
		pay0.kind = fq_data.kind;
		pay0.negx = fq_data.prodx < PROD_W'(dims.dw);
		pay0.negy = fq_data.prody < PROD_W'(dims.dh);
		pay0.wx   = fq_data.wx;
		pay0.wy   = fq_data.wy;
		pay0.wval = fq_data.wval;
		dx0.rem   = DEN_W'(tx >> CELL_W);
		dx0.low   = {tx[CELL_W-1:0], {FRAC_W{1'b0}}};
		dx0.quo   = '0;
		dy0.rem   = DEN_W'(ty >> CELL_W);
		dy0.low   = {ty[CELL_W-1:0], {FRAC_W{1'b0}}};
		dy0.quo   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= QB; i++) begin
				vld_q[i] <= 1'b0;
			end
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= fq_valid;
			for (int i = 0; i < QB; i++) begin
				vld_q[i+1] <= vld_q[i];
			end
			vld_s1    <= vld_q[QB];
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			out_vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pay_q[0] <= pay0;
			dx_q[0]  <= dx0;
			dy_q[0]  <= dy0;
			for (int i = 0; i < QB; i++) begin
				pay_q[i+1] <= pay_q[i];
				dx_q[i+1]  <= div_step(dx_q[i], denx);
				dy_q[i+1]  <= div_step(dy_q[i], deny);
			end
			pay_s1 <= pay_q[QB];
			ax_s1  <= axis_fin(dx_q[QB], pay_q[QB].negx, denx, dims.sw);
			ay_s1  <= axis_fin(dy_q[QB], pay_q[QB].negy, deny, dims.sh);
			kind_s2 <= pay_s1.kind;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
			kind_s3 <= kind_s2;
			b1_s3   <= ay_s2.w1;
			s0_s3   <= p00 * a0 + p10 * ax_s2.w1;
			s1_s3   <= p01 * a0 + p11 * ax_s2.w1;
			kind_s4 <= kind_s3;
			m0_s4   <= (COEF_ONE - b1_s3) * s0_s3[SUM_W-1:4];
			m1_s4   <= b1_s3 * s1_s3[SUM_W-1:4];
			status_q <= kind_s4 == KIND_ERROR;
			result_q <= (kind_s4 == KIND_READ) ? vsum[PIX_W+1:2] : '0;
		end
	end

	// Four banks split by column and row parity: neighbors of different parity come from different banks
	for (genvar g = 0; g < 4; g++) begin : g_bank
		localparam logic XP = 1'((g % 2));
		localparam logic YP = 1'((g / 2));
		logic [CELL_W-1:0]  col;
		logic [CELL_W-1:0]  row;
		logic [BANK_AW-1:0] raddr;
		logic [BANK_AW-1:0] waddr;
		logic               we;

		assign col   = (ax_s1.c0[0] == XP) ? ax_s1.c0 : ax_s1.c1;
		assign row   = (ay_s1.c0[0] == YP) ? ay_s1.c0 : ay_s1.c1;
		assign raddr = {row[CELL_W-1:1], col[CELL_W-1:1]};
		assign waddr = {pay_s1.wy[CELL_W-1:1], pay_s1.wx[CELL_W-1:1]};
		assign we    = adv && vld_s1 && (pay_s1.kind == KIND_WRITE) &&
			(pay_s1.wx[0] == XP) && (pay_s1.wy[0] == YP);

		bir_ram #(
			.WIDTH(PIX_W),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(waddr),
			.wdata(pay_s1.wval),
			.re   (adv),
			.raddr(raddr),
			.rdata(rd[g])
		);
	end

	always_comb begin
		p00  = rd[{ay_s2.c0[0], ax_s2.c0[0]}];
		p10  = rd[{ay_s2.c0[0], ax_s2.c1[0]}];
		p01  = rd[{ay_s2.c1[0], ax_s2.c0[0]}];
		p11  = rd[{ay_s2.c1[0], ax_s2.c1[0]}];
		a0   = COEF_ONE - ax_s2.w1;
		vsum = VSUM_W'(m0_s4[MUL_W-1:16]) + VSUM_W'(m1_s4[MUL_W-1:16]) + VSUM_W'(2);
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.result_pixel = result_q;
	assign rsp.status       = status_q;

	`BIR_NEXT(a_pop_load, fq_pop, vld_q[0], "popped transaction lost")
	`BIR_ASSERT(a_wt_max, !vld_s1 || ((ax_s1.w1 <= COEF_ONE) && (ay_s1.w1 <= COEF_ONE)),
		"weight above unity")
	`BIR_ASSERT(a_cell_lim, !vld_s1 || (pay_s1.kind != KIND_READ) ||
		((SDIM_W'(ax_s1.c1) < dims.sw) && (SDIM_W'(ay_s1.c1) < dims.sh)),
		"neighbor outside source image")
	`BIR_ASSERT(a_err_zero, !out_vld_q || !status_q || (result_q == '0), "error with pixel data")
endmodule

### hw/rtl/bilinear_image_resize_top.sv
// ---------------------------------------------------------------------------
// bilinear_image_resize_top
// Stores an 8-bit source image and returns bilinear resized pixels on read.
// ---------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  req       in   valid/ready   func, pixel_x, pixel_y, pixel_value
//  rsp       out  valid/ready   result_pixel, status
//  cfg_*     in   cfg_we only   cfg_index, cfg_data
//
// One transaction per cycle sustained while rsp is ready; each axis is divided in a
// bit-per-stage division pipeline.
// The source image lives in four parity banks so all four neighbors read in the same cycle.
// Reset clears control and loads the size registers with their defaults; image memory is undefined until written.
// A stalled rsp holds the back end; the front queue keeps taking up to four requests.
module bilinear_image_resize_top import bir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	bir_in_if.sink               req,
	bir_out_if.source            rsp
);
	dims_t dims;
	logic  full;
	logic  push;
	fe_t   entry;
	logic  fq_valid;
	logic  fq_pop;
	fe_t   fq_data;

	bir_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.full     (full),
		.push     (push),
		.entry    (entry),
		.dims     (dims)
	);

	bir_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (entry),
		.full  (full),
		.pop   (fq_pop),
		.valid (fq_valid),
		.rdata (fq_data)
	);

	bir_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.dims    (dims),
		.fq_valid(fq_valid),
		.fq_data (fq_data),
		.fq_pop  (fq_pop),
		.rsp     (rsp)
	);
endmodule
